### sv/scic_pkg.sv
package scic_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_W       = 15;
  localparam int HIT_W          = 2;

  localparam logic [HIT_W-1:0] HIT_NONE = 2'd0;
  localparam logic [HIT_W-1:0] HIT_ONE  = 2'd1;
  localparam logic [HIT_W-1:0] HIT_TWO  = 2'd2;

  // stage enables for the two-stage split multiplier
  typedef struct packed {
    logic pp_en;
    logic sum_en;
  } scic_mul_ctl_t;

endpackage

### sv/scic_if.sv
interface scic_in_if import scic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic        [RADIUS_W-1:0]   radius;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, radius, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, radius, start_x, start_y, end_x, end_y, output ready);
endinterface

interface scic_out_if import scic_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HIT_W-1:0] hit_count;

  modport source (output valid, hit_count, input ready);
  modport sink   (input valid, hit_count, output ready);
endinterface

### sv/scic_wmul.sv
module scic_wmul import scic_pkg::*; #(
  parameter int W = 2 * COORD_BITS_DEF + 2
) (
  input  logic            clk,
  input  scic_mul_ctl_t   ctl,
  input  logic [W-1:0]    op_a,
  input  logic [W-1:0]    op_b,
  output logic [2*W-1:0]  prod
);

  localparam int L  = (W + 1) / 2;
  localparam int H  = W - L;
  localparam int LL = 2 * L;
  localparam int LH = L + H;
  localparam int HH = 2 * H;
  localparam int PW = 2 * W;

  logic [L-1:0]  a_lo, b_lo;
  logic [H-1:0]  a_hi, b_hi;
  logic [LL-1:0] ll_r, ll_nxt;
  logic [LH-1:0] lh_r, lh_nxt, hl_r, hl_nxt;
  logic [HH-1:0] hh_r, hh_nxt;
  logic [PW-1:0] prod_r, prod_nxt;

  assign a_lo = op_a[L-1:0];
  assign a_hi = op_a[W-1:L];
  assign b_lo = op_b[L-1:0];
  assign b_hi = op_b[W-1:L];

  // partial products of the half words
  always_comb begin
    ll_nxt = LL'(a_lo) * LL'(b_lo);
    lh_nxt = LH'(a_lo) * LH'(b_hi);
    hl_nxt = LH'(a_hi) * LH'(b_lo);
    hh_nxt = HH'(a_hi) * HH'(b_hi);
  end

  always_comb begin
    prod_nxt = PW'(ll_r) + (PW'(lh_r) << L) + (PW'(hl_r) << L) + (PW'(hh_r) << LL);
  end

  always_ff @(posedge clk) begin
    if (ctl.pp_en) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
    end
    if (ctl.sum_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

### sv/segment_circle_intersection_count.sv
// Segment / circle intersection counter, circle centered at the origin.
// Input channel in_ch (valid/ready): radius and the two segment endpoints.
// Result channel out_ch (valid/ready): hit_count, 0, 1 or 2 circle points on
// the closed segment; exactly one result per input transaction, in order.
// Pipeline: eight pipeline registers, the last being the output register.
// Throughput: one transaction per cycle unless out_ch stalls. The stages are
// input differences, coordinate products, quadratic sums, magnitudes, two
// stages of split double-width multipliers (h^2, (a+h)^2, a*|c|),
// discriminant, root tests.
// Stall: each stage holds while the stage after it is full and held, so
// bubbles close up and in_ch.ready drops only once the pipe is full behind a
// stalled output; nothing is lost or repeated.
// Reset: synchronous, active low; all stage valid bits clear, the pipe is
// empty and in_ch.ready is high from the first cycle after reset.
module segment_circle_intersection_count import scic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  scic_in_if.sink     in_ch,
  scic_out_if.source  out_ch
);

  localparam int N    = COORD_BITS;
  localparam int CW   = N + 1;
  localparam int W    = 2 * N + 2;
  localparam int PW   = 2 * W;
  localparam int DW   = PW + 1;
  localparam int RB   = (N - 1 < RADIUS_W) ? N - 1 : RADIUS_W;
  localparam int NSTG = 8;

  typedef struct packed {
    logic a_nz;
    logic h_pos;
    logic ah_neg;
    logic c_neg;
  } flags_t;

  logic [NSTG-1:0] v_r, en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ch.ready = en[0];

  // stage 1: endpoint differences
  logic signed [CW-1:0] dx1_r, dx1_nxt, dy1_r, dy1_nxt;
  logic signed [N-1:0]  x1_r, y1_r;
  logic        [RB-1:0] r1_r;

  always_comb begin
    dx1_nxt = CW'(in_ch.end_x) - CW'(in_ch.start_x);
    dy1_nxt = CW'(in_ch.end_y) - CW'(in_ch.start_y);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx1_r <= dx1_nxt;
      dy1_r <= dy1_nxt;
      x1_r  <= in_ch.start_x;
      y1_r  <= in_ch.start_y;
      r1_r  <= in_ch.radius[RB-1:0];
    end
  end

  // stage 2: coordinate products
  logic signed [W-1:0] dx_w, dy_w, x1_w, y1_w, r_w;
  logic signed [W-1:0] dxdx2_r, dxdx2_nxt, dydy2_r, dydy2_nxt;
  logic signed [W-1:0] xd2_r, xd2_nxt, yd2_r, yd2_nxt;
  logic signed [W-1:0] xx2_r, xx2_nxt, yy2_r, yy2_nxt, rr2_r, rr2_nxt;

  always_comb begin
    dx_w      = W'(dx1_r);
    dy_w      = W'(dy1_r);
    x1_w      = W'(x1_r);
    y1_w      = W'(y1_r);
    r_w       = signed'(W'(r1_r));
    dxdx2_nxt = dx_w * dx_w;
    dydy2_nxt = dy_w * dy_w;
    xd2_nxt   = x1_w * dx_w;
    yd2_nxt   = y1_w * dy_w;
    xx2_nxt   = x1_w * x1_w;
    yy2_nxt   = y1_w * y1_w;
    rr2_nxt   = r_w * r_w;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dxdx2_r <= dxdx2_nxt;
      dydy2_r <= dydy2_nxt;
      xd2_r   <= xd2_nxt;
      yd2_r   <= yd2_nxt;
      xx2_r   <= xx2_nxt;
      yy2_r   <= yy2_nxt;
      rr2_r   <= rr2_nxt;
    end
  end

  // stage 3: quadratic coefficients a, h, c
  logic        [W-1:0] a3_r, a3_nxt;
  logic signed [W-1:0] h3_r, h3_nxt, c3_r, c3_nxt;

  always_comb begin
    a3_nxt = unsigned'(dxdx2_r) + unsigned'(dydy2_r);
    h3_nxt = xd2_r + yd2_r;
    c3_nxt = xx2_r + yy2_r - rr2_r;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a3_r <= a3_nxt;
      h3_r <= h3_nxt;
      c3_r <= c3_nxt;
    end
  end

  // stage 4: magnitudes for the unsigned multipliers, sign flags
  logic signed [W:0]   a_s, h_s, ah_s;
  logic        [W-1:0] a4_r, mh4_r, mh4_nxt, mah4_r, mah4_nxt, mc4_r, mc4_nxt;
  flags_t              fl4_r, fl4_nxt, fl5_r, fl6_r, fl7_r;

  always_comb begin
    a_s             = signed'((W+1)'(a3_r));
    h_s             = (W+1)'(h3_r);
    ah_s            = a_s + h_s;
    mh4_nxt         = h3_r[W-1] ? unsigned'(-h3_r) : unsigned'(h3_r);
    mah4_nxt        = ah_s[W] ? W'(unsigned'(-ah_s)) : W'(unsigned'(ah_s));
    mc4_nxt         = c3_r[W-1] ? unsigned'(-c3_r) : unsigned'(c3_r);
    fl4_nxt.a_nz    = (a3_r != '0);
    fl4_nxt.h_pos   = !h3_r[W-1] && (h3_r != '0);
    fl4_nxt.ah_neg  = ah_s[W];
    fl4_nxt.c_neg   = c3_r[W-1];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      a4_r   <= a3_r;
      mh4_r  <= mh4_nxt;
      mah4_r <= mah4_nxt;
      mc4_r  <= mc4_nxt;
      fl4_r  <= fl4_nxt;
    end
  end

  // stages 5 and 6: h^2, (a+h)^2 and a*|c|
  scic_mul_ctl_t   mul_ctl;
  logic [PW-1:0]   hh6, aha6, ac6;

  assign mul_ctl.pp_en  = en[4];
  assign mul_ctl.sum_en = en[5];

  scic_wmul #(.W(W)) u_mul_hh (
    .clk (clk), .ctl (mul_ctl), .op_a (mh4_r), .op_b (mh4_r), .prod (hh6)
  );

  scic_wmul #(.W(W)) u_mul_aha (
    .clk (clk), .ctl (mul_ctl), .op_a (mah4_r), .op_b (mah4_r), .prod (aha6)
  );

  scic_wmul #(.W(W)) u_mul_ac (
    .clk (clk), .ctl (mul_ctl), .op_a (a4_r), .op_b (mc4_r), .prod (ac6)
  );

  always_ff @(posedge clk) begin
    if (en[4]) fl5_r <= fl4_r;
    if (en[5]) fl6_r <= fl5_r;
  end

  // stage 7: quarter discriminant d = h^2 - a*c
  logic signed [DW-1:0] hh_d, ac_d, d7_r, d7_nxt;
  logic        [PW-1:0] hh7_r, aha7_r;

  always_comb begin
    hh_d   = signed'(DW'(hh6));
    ac_d   = signed'(DW'(ac6));
    d7_nxt = fl6_r.c_neg ? hh_d + ac_d : hh_d - ac_d;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      d7_r   <= d7_nxt;
      hh7_r  <= hh6;
      aha7_r <= aha6;
      fl7_r  <= fl6_r;
    end
  end

  // stage 8: root range tests against the squared bounds
  logic signed [DW-1:0] hh_s, aha_s;
  logic                 d_ge_hh, d_le_hh, d_ge_aha, d_le_aha, d_nonneg, d_nz;
  logic                 in1, in2;
  logic [HIT_W-1:0]     hit8_r, hit8_nxt;

  always_comb begin
    hh_s     = signed'(DW'(hh7_r));
    aha_s    = signed'(DW'(aha7_r));
    d_ge_hh  = d7_r >= hh_s;
    d_le_hh  = d7_r <= hh_s;
    d_ge_aha = d7_r >= aha_s;
    d_le_aha = d7_r <= aha_s;
    d_nonneg = !d7_r[DW-1];
    d_nz     = (d7_r != '0);
    // exit root: 0 <= t1 <= 1
    in1      = (!fl7_r.h_pos || d_ge_hh) && !fl7_r.ah_neg && d_le_aha;
    // entry root: 0 <= t2 <= 1
    in2      = !fl7_r.h_pos && d_le_hh && (!fl7_r.ah_neg || d_ge_aha);
    if (fl7_r.a_nz && d_nonneg) begin
      hit8_nxt = HIT_W'(in1) + HIT_W'(in2 && d_nz);
    end else begin
      hit8_nxt = HIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      hit8_r <= hit8_nxt;
    end
  end

  assign out_ch.valid     = v_r[NSTG-1];
  assign out_ch.hit_count = hit8_r;

endmodule

### sv/scic_checker.sv
module scic_checker import scic_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [HIT_W-1:0] hit_count
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hit_count))
    else $error("scic: held result changed or dropped");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (hit_count == HIT_NONE || hit_count == HIT_ONE ||
                   hit_count == HIT_TWO))
    else $error("scic: hit_count out of range");

  // with no result waiting the pipe can always take a transaction
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("scic: input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("scic: result valid after reset");

  // a stalled input only happens behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("scic: input stalled while output moves");

endmodule

bind segment_circle_intersection_count scic_checker u_scic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .hit_count (out_ch.hit_count)
);

### dv/tb_segment_circle_intersection_count.sv
module tb_segment_circle_intersection_count import scic_pkg::*;;

  localparam int CW          = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS    = 22;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } seg_t;

  // typed = 1: hits is the known answer, otherwise the predictor decides
  typedef struct packed {
    bit               typed;
    logic [HIT_W-1:0] hits;
    seg_t             seg;
  } dir_row_t;

  logic clk;
  logic rst_n;

  scic_in_if  in_ch ();
  scic_out_if out_ch ();

  segment_circle_intersection_count u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [HIT_W-1:0] hits_pending [$];
  int tx_idle_pct;
  int rx_idle_pct;
  bit long_stall_req;
  int hold_left;
  int mismatches;
  int sent_count;
  int result_count;
  int cycle_count;
  int in_stall_cycles;
  int hit_tally [0:3];

  dir_row_t dir_table [DIR_ROWS] = '{
    '{1'b1, HIT_NONE, '{15'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
    '{1'b1, HIT_NONE, '{15'd5, 16'sd3, 16'sd4, 16'sd3, 16'sd4}},
    '{1'b1, HIT_TWO,  '{15'd10, -16'sd20, 16'sd0, 16'sd20, 16'sd0}},
    '{1'b1, HIT_ONE,  '{15'd10, -16'sd20, 16'sd10, 16'sd20, 16'sd10}},
    '{1'b1, HIT_NONE, '{15'd10, -16'sd20, 16'sd11, 16'sd20, 16'sd11}},
    '{1'b1, HIT_NONE, '{15'd10, -16'sd1, 16'sd0, 16'sd1, 16'sd0}},
    '{1'b1, HIT_ONE,  '{15'd10, 16'sd0, 16'sd0, 16'sd20, 16'sd0}},
    '{1'b1, HIT_ONE,  '{15'd10, 16'sd10, 16'sd0, 16'sd20, 16'sd0}},
    '{1'b1, HIT_ONE,  '{15'd10, 16'sd20, 16'sd0, 16'sd10, 16'sd0}},
    '{1'b1, HIT_TWO,  '{15'd10, -16'sd10, 16'sd0, 16'sd10, 16'sd0}},
    '{1'b1, HIT_ONE,  '{15'd10, 16'sd0, 16'sd10, 16'sd20, 16'sd10}},
    '{1'b1, HIT_NONE, '{15'd10, 16'sd20, 16'sd0, 16'sd30, 16'sd0}},
    '{1'b1, HIT_ONE,  '{15'd0, -16'sd5, 16'sd0, 16'sd5, 16'sd0}},
    '{1'b1, HIT_NONE, '{15'd0, 16'sd3, -16'sd7, 16'sd9, 16'sd2}},
    '{1'b1, HIT_NONE, '{15'd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}},
    '{1'b1, HIT_NONE, '{15'd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768}},
    '{1'b1, HIT_TWO,  '{15'd32767, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0}},
    '{1'b1, HIT_NONE, '{15'd32767, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767}},
    '{1'b0, HIT_NONE, '{15'd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}},
    '{1'b0, HIT_NONE, '{15'd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}},
    '{1'b0, HIT_NONE, '{15'd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1}},
    '{1'b0, HIT_NONE, '{15'h5555, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555}}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact test of sqrt(d) >= k and sqrt(d) <= k for d >= 0
  function automatic bit root_at_least(input logic signed [127:0] d, input longint k);
    logic signed [127:0] kw;
    kw = k;
    if (k <= 0) return 1'b1;
    return d >= kw * kw;
  endfunction

  function automatic bit root_at_most(input logic signed [127:0] d, input longint k);
    logic signed [127:0] kw;
    kw = k;
    if (k < 0) return 1'b0;
    return kw * kw >= d;
  endfunction

  function automatic logic [HIT_W-1:0] predict_hits(input seg_t s);
    longint r, x1, y1, x2, y2, dx, dy, a, h, c;
    logic signed [127:0] hw, aw, cw, disc;
    logic [HIT_W-1:0] n;
    r  = s.radius;
    x1 = s.sx;
    y1 = s.sy;
    x2 = s.ex;
    y2 = s.ey;
    dx = x2 - x1;
    dy = y2 - y1;
    a  = dx * dx + dy * dy;
    h  = x1 * dx + y1 * dy;
    c  = x1 * x1 + y1 * y1 - r * r;
    hw = h;
    aw = a;
    cw = c;
    disc = hw * hw - aw * cw;
    n = HIT_NONE;
    if (a != 0 && disc >= 0) begin
      if (root_at_least(disc, h) && root_at_most(disc, a + h)) n = n + 1'b1;
      // a tangent point is a double root and counts once
      if (disc != 0 && root_at_most(disc, -h) && root_at_least(disc, -h - a)) n = n + 1'b1;
    end
    return n;
  endfunction

  function automatic logic signed [CW-1:0] near_coord(input int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return CW'(v);
  endfunction

  // mostly segments scaled to the circle, so that crossings, touches and
  // endpoints on the circle come up often
  function automatic seg_t random_segment();
    seg_t s;
    int kind, r, k, px, py, t;
    kind = $urandom_range(9);
    s.radius = RADIUS_W'($urandom);
    s.sx = CW'($urandom);
    s.sy = CW'($urandom);
    s.ex = CW'($urandom);
    s.ey = CW'($urandom);
    r = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 300);
    case (kind)
      2, 3, 4: begin
        s.radius = RADIUS_W'(r);
        s.sx = near_coord(2 * r + 2);
        s.sy = near_coord(2 * r + 2);
        s.ex = near_coord(2 * r + 2);
        s.ey = near_coord(2 * r + 2);
      end
      5: begin
        s.radius = RADIUS_W'(r);
        s.sy = $urandom_range(1) ? CW'(r) : CW'(-r);
        s.ey = s.sy;
        s.sx = near_coord(2 * r + 2);
        s.ex = near_coord(2 * r + 2);
        if ($urandom_range(1)) begin
          {s.sx, s.sy} = {s.sy, s.sx};
          {s.ex, s.ey} = {s.ey, s.ex};
        end
      end
      6, 7: begin
        k = $urandom_range(1, 6553);
        if ($urandom_range(3) == 0) k = $urandom_range(1, 8);
        px = $urandom_range(1) ? 3 * k : 5 * k;
        py = (px == 3 * k) ? 4 * k : 0;
        if ($urandom_range(1)) px = -px;
        if ($urandom_range(1)) py = -py;
        if ($urandom_range(1)) begin
          t = px;
          px = py;
          py = t;
        end
        s.radius = RADIUS_W'(5 * k);
        s.sx = CW'(px);
        s.sy = CW'(py);
        if (kind == 6) begin
          // zero-length segment, on the circle or just off it
          if ($urandom_range(1)) s.sx = CW'(px + 1);
          s.ex = s.sx;
          s.ey = s.sy;
        end else begin
          s.ex = near_coord(10 * k + 2);
          s.ey = near_coord(10 * k + 2);
          if ($urandom_range(1)) begin
            {s.sx, s.ex} = {s.ex, s.sx};
            {s.sy, s.ey} = {s.ey, s.sy};
          end
        end
      end
      8, 9: begin
        s.radius = RADIUS_W'($urandom_range(12));
        s.sx = near_coord(16);
        s.sy = near_coord(16);
        s.ex = near_coord(16);
        s.ey = near_coord(16);
      end
      default: ;
    endcase
    return s;
  endfunction

  // called right after a rising edge; returns at the edge that takes the transaction
  task automatic send_segment(input seg_t s, input bit typed, input logic [HIT_W-1:0] known);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.radius  <= s.radius;
    in_ch.start_x <= s.sx;
    in_ch.start_y <= s.sy;
    in_ch.end_x   <= s.ex;
    in_ch.end_y   <= s.ey;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hits_pending.push_back(typed ? known : predict_hits(s));
    sent_count++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_segment(random_segment(), 1'b0, HIT_NONE);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [HIT_W-1:0] got,
                                 input logic [HIT_W-1:0] want);
    mismatches++;
    $display("mismatch %0d: %s at result %0d: hit_count %0d, expected %0d",
             mismatches, what, result_count, got, want);
  endtask

  // result side: check every transaction, then decide ready for the next cycle
  always @(posedge clk) begin
    logic [HIT_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hits_pending.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.hit_count, HIT_NONE);
      end else begin
        want = hits_pending.pop_front();
        if (out_ch.hit_count !== want) report_mismatch("wrong count", out_ch.hit_count, want);
        hit_tally[want]++;
      end
      result_count++;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (in_ch.valid && !in_ch.ready && rst_n) in_stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, hits_pending.size());
      $display("segment_circle_intersection_count regression: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.radius   = '0;
    in_ch.start_x  = '0;
    in_ch.start_y  = '0;
    in_ch.end_x    = '0;
    in_ch.end_y    = '0;
    out_ch.ready   = 1'b0;
    long_stall_req = 1'b0;
    hold_left      = 0;
    tx_idle_pct    = 16;
    rx_idle_pct    = 66;
    rst_n          = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_segment(dir_table[i].seg, dir_table[i].typed, dir_table[i].hits);
    send_random(500);

    // hold the result side long enough that the pipe fills and stalls the input
    wait_drained();
    tx_idle_pct = 0;
    long_stall_req = 1'b1;
    send_random(60);
    wait_drained();

    tx_idle_pct = 66;
    rx_idle_pct = 16;
    send_random(500);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(640);
    wait_drained();
    repeat (16) @(posedge clk);

    $display("sent %0d segments (%0d directed), %0d results: %0d none, %0d one, %0d two",
             sent_count, DIR_ROWS, result_count, hit_tally[0], hit_tally[1], hit_tally[2]);
    $display("input held off %0d cycles by back-pressure, %0d mismatches",
             in_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("segment_circle_intersection_count regression: pass");
    end else begin
      $display("segment_circle_intersection_count regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/scic_pkg.sv
sv/scic_if.sv
sv/scic_wmul.sv
sv/segment_circle_intersection_count.sv
sv/scic_checker.sv
dv/tb_segment_circle_intersection_count.sv
